FILE: rtl/mhre_pkg.sv
// Shared types and constants for the mail header recipient extractor.
// Holds parse modes, result kinds, drain states, keyword tables and the
// action record passed from the parser to the top level. No dependencies.
package mhre_pkg;

	// Address buffer size and the widths that follow from it
	localparam int ADDR_MAX = 62;
	localparam int LEN_W    = $clog2(ADDR_MAX + 1);
	localparam int IDX_W    = $clog2(ADDR_MAX);

	// Header parse modes
	typedef enum logic [2:0] {
		MODE_FIRST,
		MODE_LINE,
		MODE_MATCH,
		MODE_FIELD,
		MODE_SKIP,
		MODE_DONE
	} mode_t;

	// Result kinds carried on the output tuser
	typedef enum logic [1:0] {
		KIND_ADDR = 2'd0,
		KIND_END  = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// Address run drain sequencer
	typedef enum logic [1:0] {
		DR_IDLE,
		DR_READ,
		DR_SEND
	} drain_t;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Recipient keywords in lower case: to:, cc:, bcc:
	localparam int KW_NUM = 3;
	localparam logic [7:0] KW_TEXT [KW_NUM][4] = '{
		'{8'h74, 8'h6F, 8'h3A, 8'h00},
		'{8'h63, 8'h63, 8'h3A, 8'h00},
		'{8'h62, 8'h63, 8'h63, 8'h3A}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd3, 3'd4};
	localparam logic [KW_NUM-1:0] KW_ALL = '1;

	// Action for one accepted byte
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       wr_data;
		logic             flush;
		logic [LEN_W-1:0] flush_len;
		logic             mark;
		kind_t            mark_kind;
	} parse_act_t;

endpackage

FILE: rtl/mail_header_recipient_extractor.sv
// Top level of the mail header recipient extractor.
// Depends on mhre_pkg, mhre_parse and mhre_ram (address buffer).

// Takes a message one byte per beat and returns the addresses found on To:,
// Cc: and Bcc: header lines as runs of address beats (tuser 0, tlast on the
// final byte), then one marker beat: end of recipients (tuser 1) at the blank
// line, or invalid header (tuser 2) if no recipient line came or the message
// ended first. A byte that closes an address holds the input while the run is
// read back from the address buffer RAM, through a read state and a send state
// per byte. The input is also held while a result waits unread.
module mail_header_recipient_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // end_of_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // last
);

	mhre_pkg::parse_act_t           act;
	mhre_pkg::drain_t               dr_q, dr_d;
	logic [mhre_pkg::LEN_W-1:0]     drain_len_q;
	logic [mhre_pkg::IDX_W-1:0]     rd_idx_q;
	logic [7:0]                     rd_data;
	logic                           accept;
	logic                           slot_free;
	logic                           last_beat;
	logic                           load_mark;
	logic                           load_addr;
	logic                           out_valid_q;
	mhre_pkg::kind_t                out_kind_q;
	logic [7:0]                     out_byte_q;
	logic                           out_last_q;

	// Accept a byte only when idle and the output slot can take a marker
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (dr_q == mhre_pkg::DR_IDLE) && slot_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mhre_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (accept),
		.in_byte (s_axis_tdata),
		.eom     (s_axis_tlast),
		.act     (act)
	);

	mhre_ram #(
		.WIDTH (8),
		.DEPTH (mhre_pkg::ADDR_MAX)
	) u_buf (
		.clk     (clk),
		.wr_en   (act.wr_en),
		.wr_addr (act.wr_idx),
		.wr_data (act.wr_data),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	assign last_beat = (mhre_pkg::LEN_W'(rd_idx_q) + mhre_pkg::LEN_W'(1)) == drain_len_q;
	assign load_mark = accept && act.mark;
	assign load_addr = (dr_q == mhre_pkg::DR_SEND) && slot_free;

	// Drain sequencer next state
	always_comb begin
		dr_d = dr_q;
		unique case (dr_q)
			mhre_pkg::DR_IDLE: begin
				if (accept && act.flush) begin
					dr_d = mhre_pkg::DR_READ;
				end
			end
			mhre_pkg::DR_READ: begin
				dr_d = mhre_pkg::DR_SEND;
			end
			mhre_pkg::DR_SEND: begin
				if (slot_free) begin
					dr_d = last_beat ? mhre_pkg::DR_IDLE : mhre_pkg::DR_READ;
				end
			end
			default: begin
				dr_d = mhre_pkg::DR_IDLE;
			end
		endcase
	end

	// Drain state and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_q        <= mhre_pkg::DR_IDLE;
			drain_len_q <= '0;
			rd_idx_q    <= '0;
		end else begin
			dr_q <= dr_d;
			if (accept && act.flush) begin
				drain_len_q <= act.flush_len;
				rd_idx_q    <= '0;
			end else if (load_addr && !last_beat) begin
				rd_idx_q <= rd_idx_q + mhre_pkg::IDX_W'(1);
			end
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_mark || load_addr) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload: marker or buffered address byte
	always_ff @(posedge clk) begin
		if (load_mark) begin
			out_kind_q <= act.mark_kind;
			out_byte_q <= 8'h00;
			out_last_q <= 1'b1;
		end else if (load_addr) begin
			out_kind_q <= mhre_pkg::KIND_ADDR;
			out_byte_q <= rd_data;
			out_last_q <= last_beat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/mhre_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies; width and depth are parameters.
module mhre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/mhre_parse.sv
// Header line parser: keyword match, field scan and address collection.
// Depends on mhre_pkg; reports buffer writes, flushes and markers per byte.
module mhre_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             in_byte,
	input  logic                   eom,
	output mhre_pkg::parse_act_t   act
);

	mhre_pkg::mode_t                   mode_q, mode_d;
	logic [2:0]                        pos_q, pos_d;
	logic [mhre_pkg::KW_NUM-1:0]       cand_q, cand_d;
	logic [mhre_pkg::LEN_W-1:0]        len_q, len_d;
	logic                              seen_q, seen_d;
	logic                              skip_q, skip_d;

	logic [7:0]                        lower;
	logic                              at_line;
	logic [2:0]                        p_sel;
	logic [mhre_pkg::KW_NUM-1:0]       c_sel;
	logic [mhre_pkg::KW_NUM-1:0]       keep;
	logic                              kw_done;
	logic                              is_eol;
	logic                              header_end;

	// Fold upper case to lower case
	assign lower = (in_byte >= mhre_pkg::CH_UC_A && in_byte <= mhre_pkg::CH_UC_Z) ?
		in_byte + mhre_pkg::CASE_OFS : in_byte;
	assign is_eol = (in_byte == mhre_pkg::CH_CR) || (in_byte == mhre_pkg::CH_LF);
	assign at_line = (mode_q == mhre_pkg::MODE_LINE) ||
		((mode_q == mhre_pkg::MODE_FIRST) && (in_byte != mhre_pkg::CH_LF));

	// Keyword compare; a line start restarts from the first position
	assign p_sel = at_line ? 3'd0 : pos_q;
	assign c_sel = at_line ? mhre_pkg::KW_ALL : cand_q;

	always_comb begin
		keep    = '0;
		kw_done = 1'b0;
		for (int k = 0; k < mhre_pkg::KW_NUM; k++) begin
			if (c_sel[k] && (p_sel < mhre_pkg::KW_LEN[k]) &&
				(mhre_pkg::KW_TEXT[k][p_sel[1:0]] == lower)) begin
				keep[k] = 1'b1;
				if (p_sel + 3'd1 == mhre_pkg::KW_LEN[k]) begin
					kw_done = 1'b1;
				end
			end
		end
	end

	// Next state and per-byte action
	always_comb begin
		mode_d         = mode_q;
		pos_d          = pos_q;
		cand_d         = cand_q;
		len_d          = len_q;
		seen_d         = seen_q;
		skip_d         = skip_q;
		header_end     = 1'b0;
		act            = '0;
		act.wr_idx     = len_q[mhre_pkg::IDX_W-1:0];
		act.wr_data    = in_byte;
		act.flush_len  = len_q;
		act.mark_kind  = mhre_pkg::KIND_BAD;

		unique case (mode_q)
			mhre_pkg::MODE_FIRST: begin
				if (in_byte == mhre_pkg::CH_LF) begin
					mode_d = mhre_pkg::MODE_LINE;
				end
			end
			mhre_pkg::MODE_LINE: begin
			end
			mhre_pkg::MODE_MATCH: begin
				cand_d = keep;
				pos_d  = pos_q + 3'd1;
				if (kw_done) begin
					seen_d = 1'b1;
					mode_d = mhre_pkg::MODE_FIELD;
					skip_d = 1'b1;
					len_d  = '0;
				end else if (keep == '0) begin
					mode_d = (in_byte == mhre_pkg::CH_LF) ? mhre_pkg::MODE_LINE :
						mhre_pkg::MODE_SKIP;
				end
			end
			mhre_pkg::MODE_FIELD: begin
				if (!(skip_q && (in_byte == mhre_pkg::CH_SP || in_byte == mhre_pkg::CH_TAB)))
				begin
					skip_d = 1'b0;
					if (in_byte == mhre_pkg::CH_LT) begin
						len_d  = '0;
						skip_d = 1'b1;
					end else if (in_byte == mhre_pkg::CH_GT || in_byte == mhre_pkg::CH_COMMA)
					begin
						act.flush = (len_q != '0);
						len_d     = '0;
						skip_d    = 1'b1;
					end else if (is_eol) begin
						act.flush = (len_q != '0);
						len_d     = '0;
						mode_d    = (in_byte == mhre_pkg::CH_LF) ? mhre_pkg::MODE_LINE :
							mhre_pkg::MODE_SKIP;
					end else if (len_q < mhre_pkg::LEN_W'(mhre_pkg::ADDR_MAX)) begin
						act.wr_en = take;
						len_d     = len_q + mhre_pkg::LEN_W'(1);
					end
				end
			end
			mhre_pkg::MODE_SKIP: begin
				if (in_byte == mhre_pkg::CH_LF) begin
					mode_d = mhre_pkg::MODE_LINE;
				end
			end
			default: begin
				mode_d = mhre_pkg::MODE_DONE;
			end
		endcase

		// Line start: keyword, blank line, or a line to skip
		if (at_line) begin
			cand_d = keep;
			pos_d  = 3'd1;
			if (kw_done) begin
				seen_d = 1'b1;
				mode_d = mhre_pkg::MODE_FIELD;
				skip_d = 1'b1;
				len_d  = '0;
			end else if (keep != '0) begin
				mode_d = mhre_pkg::MODE_MATCH;
			end else if (is_eol) begin
				act.mark      = 1'b1;
				act.mark_kind = seen_q ? mhre_pkg::KIND_END : mhre_pkg::KIND_BAD;
				mode_d        = mhre_pkg::MODE_DONE;
				header_end    = 1'b1;
			end else begin
				mode_d = mhre_pkg::MODE_SKIP;
			end
		end

		// Message end: drop any address, flag a missing header end, restart
		if (eom) begin
			act.flush = 1'b0;
			if (!header_end && mode_q != mhre_pkg::MODE_DONE) begin
				act.mark      = 1'b1;
				act.mark_kind = mhre_pkg::KIND_BAD;
			end
			mode_d = mhre_pkg::MODE_FIRST;
			pos_d  = 3'd0;
			cand_d = mhre_pkg::KW_ALL;
			len_d  = '0;
			seen_d = 1'b0;
			skip_d = 1'b0;
		end
	end

	// Parse state registers, advanced once per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mhre_pkg::MODE_FIRST;
			pos_q  <= 3'd0;
			cand_q <= mhre_pkg::KW_ALL;
			len_q  <= '0;
			seen_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			cand_q <= cand_d;
			len_q  <= len_d;
			seen_q <= seen_d;
			skip_q <= skip_d;
		end
	end

endmodule

FILE: rtl/mhre_check.sv
// Port-level checker for the mail header recipient extractor, bound to it.
// Depends on mhre_pkg for result kind codes.
module mhre_check (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// Markers carry a zero byte and close their run
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != mhre_pkg::KIND_ADDR) |->
			(m_axis_tdata == 8'h00) && m_axis_tlast)
		else $error("marker beat malformed");

	// No input taken in the middle of an address run
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == mhre_pkg::KIND_ADDR) && !m_axis_tlast |->
			!s_axis_tready)
		else $error("input ready during an address run");

endmodule

bind mail_header_recipient_extractor mhre_check u_check (.*);

FILE: verif/mhre_checker.sv
// Checker for the mail header recipient extractor: watches both stream sides,
// predicts the address runs and markers for every accepted byte and compares.
// Depends on mhre_pkg for the result kinds, parse modes and character codes.
module mhre_checker
	import mhre_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // end_of_message
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
	input  logic [1:0] m_axis_tuser,   // [1:0] kind
	input  logic       m_axis_tlast,   // last
	output int         errors,
	output int         beats_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	// Recipient keywords, lower case, and their lengths
	localparam logic [7:0] KEYWORD [3][4] = '{
		'{"t", "o", ":", 8'h00},
		'{"c", "c", ":", 8'h00},
		'{"b", "c", "c", ":"}
	};
	localparam int KEYWORD_LEN [3] = '{3, 3, 4};

	// Shadow parser state
	mode_t      mode;
	logic [2:0] kw_pos;
	logic [2:0] kw_live;
	logic [7:0] addr_buf [ADDR_MAX];
	int         addr_len;
	logic       rcpt_seen;
	logic       blank_skip;

	out_beat_t  recipient_beats [$];
	out_beat_t  burst [$];
	out_beat_t  got;
	int         err_count = 0;

	function automatic void clear_state();
		mode       = MODE_FIRST;
		kw_pos     = '0;
		kw_live    = 3'b111;
		addr_len   = 0;
		rcpt_seen  = 1'b0;
		blank_skip = 1'b0;
	endfunction

	// Advance keyword matching by one byte; true when a keyword completes
	function automatic logic step_keyword(input logic [7:0] b);
		logic [7:0] lc;
		logic [2:0] keep;
		logic       hit;
		int         k;
		lc   = (b >= CH_UC_A && b <= CH_UC_Z) ? b + CASE_OFS : b;
		keep = '0;
		hit  = 1'b0;
		for (k = 0; k < 3; k++) begin
			if (kw_live[k] && kw_pos < KEYWORD_LEN[k] && KEYWORD[k][kw_pos] == lc) begin
				keep[k] = 1'b1;
				if (kw_pos + 1 == KEYWORD_LEN[k])
					hit = 1'b1;
			end
		end
		kw_live = keep;
		kw_pos  = kw_pos + 3'd1;
		return hit;
	endfunction

	function automatic void enter_field();
		rcpt_seen  = 1'b1;
		mode       = MODE_FIELD;
		blank_skip = 1'b1;
		addr_len   = 0;
	endfunction

	// Emit the collected address as a run of beats, tlast on the final byte
	function automatic void drain_address();
		out_beat_t beat;
		int        i;
		for (i = 0; i < addr_len; i++) begin
			beat.kind = KIND_ADDR;
			beat.data = addr_buf[i];
			beat.last = (i == addr_len - 1);
			burst.push_back(beat);
		end
		addr_len = 0;
	endfunction

	// Work out the beats caused by one message byte
	function automatic void parse_byte(input logic [7:0] b, input logic eom);
		logic      was_done;
		logic      at_line;
		logic      ended;
		kind_t     marker;
		out_beat_t beat;
		burst.delete();
		was_done = (mode == MODE_DONE);
		at_line  = 1'b0;
		ended    = 1'b0;
		case (mode)
			MODE_FIRST: begin
				if (b == CH_LF)
					mode = MODE_LINE;
				else
					at_line = 1'b1;
			end
			MODE_LINE: at_line = 1'b1;
			MODE_MATCH: begin
				if (step_keyword(b))
					enter_field();
				else if (kw_live == '0)
					mode = (b == CH_LF) ? MODE_LINE : MODE_SKIP;
			end
			MODE_FIELD: begin
				if (!(blank_skip && (b == CH_SP || b == CH_TAB))) begin
					blank_skip = 1'b0;
					if (b == CH_LT) begin
						addr_len   = 0;
						blank_skip = 1'b1;
					end else if (b == CH_GT || b == CH_COMMA) begin
						drain_address();
						blank_skip = 1'b1;
					end else if (b == CH_CR || b == CH_LF) begin
						drain_address();
						mode = (b == CH_LF) ? MODE_LINE : MODE_SKIP;
					end else if (addr_len < ADDR_MAX) begin
						addr_buf[addr_len] = b;
						addr_len++;
					end
				end
			end
			MODE_SKIP: begin
				if (b == CH_LF)
					mode = MODE_LINE;
			end
			default: mode = MODE_DONE;
		endcase

		// Line start: a keyword, a blank line ending the header, or junk
		if (at_line) begin
			kw_pos  = '0;
			kw_live = 3'b111;
			if (step_keyword(b)) begin
				enter_field();
			end else if (kw_live != '0) begin
				mode = MODE_MATCH;
			end else if (b == CH_CR || b == CH_LF) begin
				marker = KIND_BAD;
				if (rcpt_seen)
					marker = KIND_END;
				beat = '{marker, 8'h00, 1'b1};
				burst.push_back(beat);
				mode  = MODE_DONE;
				ended = 1'b1;
			end else begin
				mode = MODE_SKIP;
			end
		end

		// Message ended early: drop any address and flag the header invalid
		if (eom) begin
			if (!ended && !was_done) begin
				burst.delete();
				beat = '{KIND_BAD, 8'h00, 1'b1};
				burst.push_back(beat);
			end
			clear_state();
		end
		foreach (burst[i])
			recipient_beats.push_back(burst[i]);
	endfunction

	task automatic report(input string msg);
		if (err_count < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Compare output beats first, then predict from the input beat
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
			recipient_beats.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (recipient_beats.size() == 0) begin
					report($sformatf("unexpected beat kind %0d data %02h last %0b",
						m_axis_tuser, m_axis_tdata, m_axis_tlast));
				end else begin
					got = recipient_beats.pop_front();
					if (m_axis_tuser !== got.kind)
						report($sformatf("kind %0d, expected %0d", m_axis_tuser, got.kind));
					if (m_axis_tdata !== got.data)
						report($sformatf("data %02h, expected %02h", m_axis_tdata, got.data));
					if (m_axis_tlast !== got.last)
						report($sformatf("last %0b, expected %0b", m_axis_tlast, got.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				parse_byte(s_axis_tdata, s_axis_tlast);
		end
		errors     <= err_count;
		beats_owed <= recipient_beats.size();
	end

endmodule

FILE: verif/testbench.sv
// Top of the recipient extractor testbench: clock, reset, message stimulus
// with random gaps and output stalls, and the final verdict.
// Depends on mhre_pkg, mail_header_recipient_extractor and mhre_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mhre_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_BYTES = 100;
	localparam string ADDR_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789@.-_";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;    // end_of_message
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic [1:0] m_axis_tuser;           // [1:0] kind
	logic       m_axis_tlast;           // last
	int         fail_count;
	int         beats_owed;

	logic [7:0] msg_bytes [$];
	int         body_len;
	bit         steady = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	mail_header_recipient_extractor i_dut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
	);

	mhre_checker i_checker (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
		.errors(fail_count), .beats_owed(beats_owed)
	);

	// Mostly no gap, often a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one byte and hold it until accepted, then maybe idle
	task automatic send_byte(input logic [7:0] b, input logic eom);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eom;
		do @(posedge clk); while (!s_axis_tready);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted beat has come out
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (beats_owed != 0);
	endtask

	// Build one message: header lines with random content, then a blank
	// line and a short body, or a cut anywhere; sometimes pure noise
	function automatic void build_message(input bit long_first);
		string      kw;
		logic [7:0] c;
		int         l, a, i, lines, naddr, len, cut, pick;
		bit         bracket;
		msg_bytes.delete();
		body_len = 0;
		if (!long_first && $urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 4) == 0)
			msg_bytes.push_back(CH_LF);
		lines = $urandom_range(1, 3);
		for (l = 0; l < lines; l++) begin
			pick = (long_first && l == 0) ? 0 : $urandom_range(0, 9);
			if (pick < 7) begin
				case ($urandom_range(0, 2))
					0: kw = "to:";
					1: kw = "cc:";
					default: kw = "bcc:";
				endcase
				len = (pick == 6) ? $urandom_range(1, kw.len() - 1) : kw.len();
				for (i = 0; i < len; i++) begin
					c = kw[i];
					if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
						c = c - CASE_OFS;
					msg_bytes.push_back(c);
				end
				if (pick == 6) begin
					// near miss on the keyword
					msg_bytes.push_back(8'($urandom_range(0, 255)));
					msg_bytes.push_back(CH_LF);
					continue;
				end
				repeat ($urandom_range(0, 2))
					msg_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
				naddr = $urandom_range(1, 3);
				for (a = 0; a < naddr; a++) begin
					len = (long_first && l == 0 && a == 0) ?
						$urandom_range(ADDR_MAX - 2, ADDR_MAX + 6) : $urandom_range(0, 8);
					bracket = ($urandom_range(0, 2) == 0);
					if (bracket) begin
						if ($urandom_range(0, 1) == 1) begin
							msg_bytes.push_back("N");
							msg_bytes.push_back("m");
							msg_bytes.push_back(CH_SP);
						end
						msg_bytes.push_back(CH_LT);
					end
					repeat (len) begin
						if ($urandom_range(0, 9) == 0)
							msg_bytes.push_back(8'($urandom_range(0, 255)));
						else
							msg_bytes.push_back(ADDR_CHARS[$urandom_range(0, ADDR_CHARS.len() - 1)]);
					end
					if (bracket)
						msg_bytes.push_back(CH_GT);
					if (a != naddr - 1) begin
						msg_bytes.push_back(CH_COMMA);
						if ($urandom_range(0, 1) == 1)
							msg_bytes.push_back(CH_SP);
					end
				end
				case ($urandom_range(0, 2))
					0: begin
						msg_bytes.push_back(CH_CR);
						msg_bytes.push_back(CH_LF);
					end
					1: msg_bytes.push_back(CH_LF);
					default: begin
						msg_bytes.push_back(CH_CR);
						msg_bytes.push_back("x");
						msg_bytes.push_back(CH_LF);
					end
				endcase
			end else begin
				// other header line, may carry a stray CR
				msg_bytes.push_back("X");
				repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom_range(8'h0D, 8'h7E)));
				msg_bytes.push_back(CH_LF);
			end
		end
		if (long_first || $urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 1) == 1) begin
				msg_bytes.push_back(CH_CR);
				body_len++;
			end
			msg_bytes.push_back(CH_LF);
			pick = $urandom_range(0, 3);
			repeat (pick) msg_bytes.push_back(8'($urandom_range(0, 255)));
			body_len += pick;
		end else begin
			cut = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > cut)
				void'(msg_bytes.pop_back());
		end
	endfunction

	// Output side: bursts of ready with random stalls, some long steady runs
	initial begin
		int run_len;
		int stall_len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			stall_len = pick_gap();
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Guard against a hang
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		string text;
		int    i;
		int    sent;
		int    msg_idx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: leading LF, blanks, '<' discards, '>' and ',' flush, empty
		// address, CR ends a field, keyword mismatch on LF, blank line end
		text = "\nTo: \t<x<a>,b\015z\nCc:q\nT\n\n";
		for (i = 0; i < text.len(); i++)
			send_byte(text[i], 1'b0);
		// final byte after the header, then one-byte messages
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(CH_CR, 1'b1);
		wait_drained();

		// Random messages
		sent    = 0;
		msg_idx = 0;
		while (sent < RANDOM_BYTES) begin
			steady = ($urandom_range(0, 3) == 0);
			build_message(msg_idx == 0);
			foreach (msg_bytes[j])
				send_byte(msg_bytes[j], j == msg_bytes.size() - 1);
			sent += msg_bytes.size() - body_len;
			if (msg_idx == 2)
				wait_drained();
			msg_idx++;
		end

		wait_drained();
		repeat (2 * ADDR_MAX + 16) @(posedge clk);
		if (fail_count == 0 && beats_owed == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mhre_pkg.sv
rtl/mhre_ram.sv
rtl/mhre_parse.sv
rtl/mail_header_recipient_extractor.sv
rtl/mhre_check.sv
verif/mhre_checker.sv
verif/testbench.sv
